// ----- rtl/dpc_pkg.sv -----
// ---------------------------------------------------------------------------
// dpc_pkg
// Shared types and constants of the debounced pulse counter unit.
// ---------------------------------------------------------------------------
package dpc_pkg;

    localparam int CHANNELS = 2;
    localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int HIST_W   = 32;
    localparam int COUNT_W  = 64;
    localparam int NPER_W   = 5;
    localparam int EMODE_W  = 2;

    localparam int ENABLE_W   = 2;
    localparam int EDGES_W    = 4;
    localparam int PERIODS_W  = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // request modes
    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_INIT   = 2'd1;
    localparam logic [1:0] MODE_SET    = 2'd2;

    // edge selection per channel
    localparam logic [1:0] EDGE_RISE = 2'd0;
    localparam logic [1:0] EDGE_FALL = 2'd1;
    localparam logic [1:0] EDGE_BOTH = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIODS = 2'd2;

    typedef struct packed {
        logic [HIST_W-1:0]  history;
        logic               level;
        logic [COUNT_W-1:0] count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic              enable;
        logic [EMODE_W-1:0] edge_mode;
        logic [NPER_W-1:0]  periods;
    } chan_cfg_t;

endpackage

// ----- rtl/dpc_ram.sv -----
// ---------------------------------------------------------------------------
// dpc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module dpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/dpc_update.sv -----
// ---------------------------------------------------------------------------
// dpc_update
// Per-request channel update: debounce, edge detect and count.
// ---------------------------------------------------------------------------
module dpc_update (
    input  logic                     in_range,
    input  logic [1:0]               mode,
    input  logic                     pin_level,
    input  logic [dpc_pkg::COUNT_W-1:0] count_value,
    input  dpc_pkg::chan_cfg_t       cfg,
    input  dpc_pkg::entry_t          cur,
    output dpc_pkg::entry_t          nxt,
    output logic                     write_en,
    output logic                     edge_counted,
    output logic [dpc_pkg::COUNT_W-1:0] pulse_total,
    output logic                     qualified_level
);
    import dpc_pkg::*;

    logic [HIST_W-1:0] mask;
    logic [HIST_W-1:0] hist_shift;
    logic [HIST_W-1:0] masked;
    logic              lvl;
    logic              counted;

    always_comb begin
        // n of zero gives an empty mask, which reads as all low
        mask       = (HIST_W'(1) << cfg.periods) - HIST_W'(1);
        hist_shift = {cur.history[HIST_W-2:0], pin_level};
        masked     = hist_shift & mask;
        if (masked == '0) begin
            lvl = 1'b0;
        end else if (masked == mask) begin
            lvl = 1'b1;
        end else begin
            lvl = cur.level;
        end
        case (cfg.edge_mode)
            EDGE_RISE: counted = !cur.level && lvl;
            EDGE_FALL: counted = cur.level && !lvl;
            EDGE_BOTH: counted = cur.level != lvl;
            default:   counted = 1'b0;
        endcase

        nxt          = cur;
        write_en     = 1'b0;
        edge_counted = 1'b0;
        if (in_range) begin
            unique case (mode)
                MODE_SAMPLE: begin
                    if (cfg.enable) begin
                        nxt.history  = hist_shift;
                        nxt.level    = lvl;
                        nxt.count    = counted ? cur.count + COUNT_W'(1) : cur.count;
                        edge_counted = counted;
                        write_en     = 1'b1;
                    end
                end
                MODE_INIT: begin
                    nxt.history = {{(HIST_W-1){1'b0}}, pin_level};
                    nxt.level   = pin_level;
                    write_en    = 1'b1;
                end
                MODE_SET: begin
                    nxt.count = count_value;
                    write_en  = 1'b1;
                end
                default: begin
                    write_en = 1'b0;
                end
            endcase
        end

        pulse_total     = in_range ? nxt.count : '0;
        qualified_level = in_range ? nxt.level : 1'b0;
    end

endmodule

// ----- rtl/debounced_pulse_counter_unit.sv -----
// ---------------------------------------------------------------------------
// debounced_pulse_counter_unit
// Multi-channel debounced edge pulse counter, channel state held in a RAM.
// ---------------------------------------------------------------------------
// The RAM is read at the accepting edge, then the update is written into
// the output register, which offers the result. Throughput: one request per
// cycle unless m_ready stalls the output, set by the single RAM read/write
// port pair; a same-channel write-back is forwarded to the next request.
// Reset: synchronous, active low; per-channel valid bits clear the state at
// once, so no clearing pass is needed. Config registers reset to zero.
module debounced_pulse_counter_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_mode,
    input  logic                              s_channel,
    input  logic                              s_pin_level,
    input  logic [dpc_pkg::COUNT_W-1:0]       s_count_value,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_result_channel,
    output logic [dpc_pkg::COUNT_W-1:0]       m_pulse_total,
    output logic                              m_qualified_level,
    output logic                              m_edge_counted,
    // configuration channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dpc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import dpc_pkg::*;

    logic [ENABLE_W-1:0]  enable_reg;
    logic [EDGES_W-1:0]   edges_reg;
    logic [PERIODS_W-1:0] periods_reg;

    logic               s1_valid_reg;
    logic [1:0]         s1_mode_reg;
    logic               s1_channel_reg;
    logic               s1_pin_reg;
    logic [COUNT_W-1:0] s1_count_reg;

    logic               m_valid_reg;
    logic               m_channel_reg;
    logic [COUNT_W-1:0] m_total_reg;
    logic               m_level_reg;
    logic               m_counted_reg;

    logic [CHANNELS-1:0] valid_reg;
    logic                wb_valid_reg;
    logic [CH_AW-1:0]    wb_addr_reg;
    entry_t              wb_data_reg;

    logic               accept;
    logic               advance;
    logic               s1_fire;
    logic [CH_AW-1:0]   s_addr;
    logic [CH_AW-1:0]   s1_addr;
    logic               s1_in_range;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             ram_entry;
    entry_t             cur_entry;
    entry_t             nxt_entry;
    chan_cfg_t          chan_cfg;
    logic               upd_we;
    logic               upd_counted;
    logic [COUNT_W-1:0] upd_total;
    logic               upd_level;
    logic               ram_we;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg  <= '0;
            edges_reg   <= '0;
            periods_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ENABLE:  enable_reg  <= cfg_data[ENABLE_W-1:0];
                CFG_EDGES:   edges_reg   <= cfg_data[EDGES_W-1:0];
                CFG_PERIODS: periods_reg <= cfg_data[PERIODS_W-1:0];
                default: ;
            endcase
        end
    end

    assign advance = !m_valid_reg || m_ready;
    assign s1_fire = s1_valid_reg && advance;
    assign s_ready = !s1_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    assign s_addr      = CH_AW'(s_channel);
    assign s1_addr     = CH_AW'(s1_channel_reg);
    assign s1_in_range = 32'(s1_channel_reg) < CHANNELS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_mode_reg    <= s_mode;
            s1_channel_reg <= s_channel;
            s1_pin_reg     <= s_pin_level;
            s1_count_reg   <= s_count_value;
        end
    end

    dpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s1_addr),
        .wdata (nxt_entry),
        .re    (accept),
        .raddr (s_addr),
        .rdata (ram_rdata)
    );

    // never-written entries read as the reset value; last write-back wins
    always_comb begin
        ram_entry = valid_reg[s1_addr] ? entry_t'(ram_rdata) : '0;
        if (wb_valid_reg && wb_addr_reg == s1_addr) begin
            cur_entry = wb_data_reg;
        end else begin
            cur_entry = ram_entry;
        end
        chan_cfg.enable    = enable_reg[s1_channel_reg];
        chan_cfg.edge_mode = edges_reg[EMODE_W*s1_channel_reg +: EMODE_W];
        chan_cfg.periods   = periods_reg[NPER_W*s1_channel_reg +: NPER_W];
    end

    dpc_update u_update (
        .in_range        (s1_in_range),
        .mode            (s1_mode_reg),
        .pin_level       (s1_pin_reg),
        .count_value     (s1_count_reg),
        .cfg             (chan_cfg),
        .cur             (cur_entry),
        .nxt             (nxt_entry),
        .write_en        (upd_we),
        .edge_counted    (upd_counted),
        .pulse_total     (upd_total),
        .qualified_level (upd_level)
    );

    assign ram_we = s1_fire && upd_we;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            wb_valid_reg <= 1'b0;
        end else if (ram_we) begin
            valid_reg[s1_addr] <= 1'b1;
            wb_valid_reg       <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_we) begin
            wb_addr_reg <= s1_addr;
            wb_data_reg <= nxt_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            m_channel_reg <= s1_channel_reg;
            m_total_reg   <= upd_total;
            m_level_reg   <= upd_level;
            m_counted_reg <= upd_counted;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_result_channel  = m_channel_reg;
    assign m_pulse_total     = m_total_reg;
    assign m_qualified_level = m_level_reg;
    assign m_edge_counted    = m_counted_reg;

endmodule

// ----- tb/debounced_pulse_counter_unit_test.sv -----
// ---------------------------------------------------------------------------
// debounced_pulse_counter_unit_test
// Self-checking bench for the debounced pulse counter unit. Requests are sent
// over the valid/ready input channel and mirrored in a local model of the
// channel histories, levels and counts. Every result is checked field by
// field against the oldest prediction. Directed cases come first, then random
// traffic under several sender and receiver idling mixes.
// ---------------------------------------------------------------------------
module debounced_pulse_counter_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dpc_pkg::*;

    // codes the package leaves unnamed
    localparam logic [1:0]           MODE_UNUSED = 2'd3;
    localparam logic [1:0]           EDGE_NONE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic               channel;
        logic [COUNT_W-1:0] total;
        logic               level;
        logic               counted;
    } pulse_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_mode = MODE_SAMPLE;
    logic               s_channel = 1'b0;
    logic               s_pin_level = 1'b0;
    logic [COUNT_W-1:0] s_count_value = '0;

    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_result_channel;
    logic [COUNT_W-1:0] m_pulse_total;
    logic               m_qualified_level;
    logic               m_edge_counted;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_ENABLE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // local copy of the channel state and registers
    logic [HIST_W-1:0]    history_q [CHANNELS];
    logic                 level_q   [CHANNELS];
    logic [COUNT_W-1:0]   count_q   [CHANNELS];
    logic [ENABLE_W-1:0]  enable_bits = '0;
    logic [EDGES_W-1:0]   edge_bits = '0;
    logic [PERIODS_W-1:0] period_bits = '0;

    pulse_result_t awaited_counts[$];
    int mismatches = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;

    // random stream state: current channel and its pin level
    logic cur_channel = 1'b0;
    logic pin_now [CHANNELS];

    debounced_pulse_counter_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_channel         (s_channel),
        .s_pin_level       (s_pin_level),
        .s_count_value     (s_count_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_channel  (m_result_channel),
        .m_pulse_total     (m_pulse_total),
        .m_qualified_level (m_qualified_level),
        .m_edge_counted    (m_edge_counted),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // shift in one request and return what the block must answer
    function automatic pulse_result_t debounce_and_count(logic [1:0] mode, logic ch, logic pin,
                                                         logic [COUNT_W-1:0] value);
        pulse_result_t r;
        logic [NPER_W-1:0]  n;
        logic [EMODE_W-1:0] edge_sel;
        logic [HIST_W-1:0]  mask;
        logic [HIST_W-1:0]  h;
        logic               prev;
        logic               lvl;
        r = '0;
        r.channel = ch;
        case (mode)
            MODE_SAMPLE: begin
                if (enable_bits[ch]) begin
                    n = period_bits[NPER_W*ch +: NPER_W];
                    edge_sel = edge_bits[EMODE_W*ch +: EMODE_W];
                    mask = (n == 0) ? '0 : ((HIST_W'(1) << n) - HIST_W'(1));
                    prev = level_q[ch];
                    lvl = prev;
                    h = {history_q[ch][HIST_W-2:0], pin};
                    history_q[ch] = h;
                    if ((h & mask) == '0)
                        lvl = 1'b0;
                    else if ((h & mask) == mask)
                        lvl = 1'b1;
                    case (edge_sel)
                        EDGE_RISE: r.counted = !prev && lvl;
                        EDGE_FALL: r.counted = prev && !lvl;
                        EDGE_BOTH: r.counted = prev != lvl;
                        default:   r.counted = 1'b0;
                    endcase
                    if (r.counted)
                        count_q[ch] = count_q[ch] + 1'b1;
                    level_q[ch] = lvl;
                end
            end
            MODE_INIT: begin
                history_q[ch] = HIST_W'(pin);
                level_q[ch] = pin;
            end
            MODE_SET: begin
                count_q[ch] = value;
            end
            default: ;
        endcase
        r.total = count_q[ch];
        r.level = level_q[ch];
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [COUNT_W-1:0] got,
                                   logic [COUNT_W-1:0] want);
        $display("mismatch on %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
        mismatches++;
    endtask

    task automatic send_request(logic [1:0] mode, logic ch, logic pin, logic [COUNT_W-1:0] value);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_channel <= ch;
        s_pin_level <= pin;
        s_count_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        awaited_counts.push_back(debounce_and_count(mode, ch, pin, value));
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_ENABLE:  enable_bits = data[ENABLE_W-1:0];
            CFG_EDGES:   edge_bits = data[EDGES_W-1:0];
            CFG_PERIODS: period_bits = data[PERIODS_W-1:0];
            default: ;
        endcase
    endtask

    // always called after wait_for_idle, so cfg_valid never drops and rises in one step
    task automatic configure(logic [CFG_DATA_W-1:0] en_data, logic [CFG_DATA_W-1:0] edge_data,
                             logic [CFG_DATA_W-1:0] per_data, bit with_unused);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_register(CFG_ENABLE, en_data);
        write_register(CFG_EDGES, edge_data);
        if (with_unused)
            write_register(CFG_UNUSED, junk);
        write_register(CFG_PERIODS, per_data);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_for_idle();
        s_valid <= 1'b0;
        while (awaited_counts.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // reset state: both channels disabled, samples must not move anything
    task automatic test_disabled_channels();
        send_request(MODE_SAMPLE, 1'b0, 1'b1, '0);
        send_request(MODE_SAMPLE, 1'b1, 1'b0, COUNT_MAX);
        send_request(MODE_UNUSED, 1'b0, 1'b1, COUNT_MAX);
        send_request(MODE_INIT, 1'b1, 1'b1, '0);
        send_request(MODE_SET, 1'b0, 1'b0, COUNT_MAX);
        send_request(MODE_SAMPLE, 1'b1, 1'b0, '0);
    endtask

    // rising on channel 0, falling on channel 1, the channel 1 count wraps through zero
    task automatic test_count_wrap();
        wait_for_idle();
        configure(10'h3, {6'h0, EDGE_FALL, EDGE_RISE}, {5'd1, 5'd1}, 1'b0);
        send_request(MODE_SAMPLE, 1'b0, 1'b1, '0);
        send_request(MODE_SAMPLE, 1'b1, 1'b0, '0);
        send_request(MODE_SET, 1'b1, 1'b1, COUNT_MAX);
        send_request(MODE_SAMPLE, 1'b1, 1'b1, '0);
        send_request(MODE_SAMPLE, 1'b1, 1'b0, '0);
    endtask

    task automatic test_edge_modes();
        wait_for_idle();
        configure(10'h3, {6'h0, EDGE_NONE, EDGE_BOTH}, {5'd1, 5'd2}, 1'b0);
        send_request(MODE_INIT, 1'b0, 1'b0, COUNT_MAX);
        send_request(MODE_SAMPLE, 1'b0, 1'b1, '0);
        send_request(MODE_SAMPLE, 1'b0, 1'b1, '0);
        send_request(MODE_SAMPLE, 1'b0, 1'b0, '0);
        send_request(MODE_SAMPLE, 1'b0, 1'b0, '0);
        send_request(MODE_SAMPLE, 1'b1, 1'b1, '0);
        send_request(MODE_SAMPLE, 1'b1, 1'b0, '0);
    endtask

    // all-ones registers (longest window, no edges), then a zero window
    task automatic test_debounce_extremes();
        wait_for_idle();
        configure('1, '1, '1, 1'b1);
        send_request(MODE_SAMPLE, 1'b0, 1'b1, '0);
        send_request(MODE_SAMPLE, 1'b1, 1'b1, '0);
        wait_for_idle();
        configure(10'h3, {6'h0, EDGE_BOTH, EDGE_BOTH}, '0, 1'b0);
        send_request(MODE_SAMPLE, 1'b0, 1'b1, '0);
        send_request(MODE_SAMPLE, 1'b1, 1'b1, '0);
        send_request(MODE_UNUSED, 1'b1, 1'b0, '0);
    endtask

    function automatic logic [NPER_W-1:0] pick_period();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 5'd1;
            2: return '1;
            default: return NPER_W'($urandom_range(2, 8));
        endcase
    endfunction

    // mostly long steady pin runs so deep windows settle, plus noisy stretches
    task automatic test_random_traffic(int idle_pct, int stall_pct);
        logic [1:0]            mode;
        logic [COUNT_W-1:0]    value;
        logic [ENABLE_W-1:0]   en;
        logic [CFG_DATA_W-1:0] en_data;
        logic [CFG_DATA_W-1:0] edge_data;
        int                    flip_pct;
        int                    r;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int seg = 0; seg < 4; seg++) begin
            wait_for_idle();
            en = ($urandom_range(0, 99) < 70) ? 2'b11 : ENABLE_W'($urandom_range(0, 2));
            en_data = CFG_DATA_W'($urandom);
            en_data[ENABLE_W-1:0] = en;
            edge_data = CFG_DATA_W'($urandom);
            configure(en_data, edge_data, {pick_period(), pick_period()},
                      $urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0: flip_pct = 3;
                1: flip_pct = 12;
                default: flip_pct = 50;
            endcase
            for (int i = 0; i < 95; i++) begin
                if ($urandom_range(0, 99) < 30)
                    cur_channel = ~cur_channel;
                if ($urandom_range(0, 99) < flip_pct)
                    pin_now[cur_channel] = ~pin_now[cur_channel];
                r = $urandom_range(0, 99);
                if (r < 4)
                    mode = MODE_INIT;
                else if (r < 8)
                    mode = MODE_SET;
                else if (r < 10)
                    mode = MODE_UNUSED;
                else
                    mode = MODE_SAMPLE;
                if ($urandom_range(0, 1))
                    value = {$urandom, $urandom};
                else
                    value = COUNT_MAX - COUNT_W'($urandom_range(0, 2));
                send_request(mode, cur_channel, pin_now[cur_channel], value);
            end
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    always @(posedge aclk) begin
        pulse_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_counts.size() == 0) begin
                report_mismatch("unrequested result", m_pulse_total, '0);
            end else begin
                want = awaited_counts.pop_front();
                if (m_result_channel !== want.channel)
                    report_mismatch("result_channel", COUNT_W'(m_result_channel),
                                    COUNT_W'(want.channel));
                if (m_pulse_total !== want.total)
                    report_mismatch("pulse_total", m_pulse_total, want.total);
                if (m_qualified_level !== want.level)
                    report_mismatch("qualified_level", COUNT_W'(m_qualified_level),
                                    COUNT_W'(want.level));
                if (m_edge_counted !== want.counted)
                    report_mismatch("edge_counted", COUNT_W'(m_edge_counted),
                                    COUNT_W'(want.counted));
            end
        end
    end

    initial begin
        for (int c = 0; c < CHANNELS; c++) begin
            history_q[c] = '0;
            level_q[c] = 1'b0;
            count_q[c] = '0;
            pin_now[c] = 1'b0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_disabled_channels();
        test_count_wrap();
        test_edge_modes();
        test_debounce_extremes();
        test_random_traffic(0, 0);
        test_random_traffic(59, 0);
        test_random_traffic(0, 59);
        test_random_traffic(38, 38);

        wait_for_idle();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("debounced_pulse_counter_unit verification clean");
        else
            $display("debounced_pulse_counter_unit verification failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("debounced_pulse_counter_unit verification failed");
        $finish;
    end

endmodule
